### rtl/core/bria_pkg.sv
// Package for the bitmap range identifier allocator: constants, codes and shared types.
package bria_pkg;

  localparam int unsigned NUM_IDS   = 65536;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned GRP_W     = 8;
  localparam int unsigned GRP_N     = 8;
  localparam int unsigned GRP_AW    = $clog2(GRP_N);
  localparam int unsigned GBIT_AW   = $clog2(GRP_W);
  localparam int unsigned WORD_W    = GRP_N * GRP_W;
  localparam int unsigned BIT_W     = $clog2(WORD_W);
  localparam int unsigned MAP_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int unsigned WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_USED      = 2'd2,
    ST_BAD_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffz_t;

endpackage

### rtl/core/bitmap_range_id_allocator.sv
// Top level of the bitmap range identifier allocator: sequencer, map RAM and datapath.
//
// Keeps one used bit per 16-bit identifier in a RAM of 64-bit words (1024 rows) and
// serves one request beat at a time: acquire (lowest free id in range_start..range_end,
// inclusive), release, or mark-used. Every accepted request yields exactly one response
// beat {status, port_out}. After reset the block sweeps the RAM to zero, one row per
// cycle; in_ready_o stays low until the sweep is done. A refused request goes from
// its start step straight to the response. Release and mark-used read their row,
// check the bit and write the row back unless a mark-used finds the bit set. An
// acquire reads the rows of its range in turn, up to 1024 for a full 64K range, one
// row per cycle, as the search shares the RAM read port and a single find-first-zero
// unit; a free bit it finds is set and written back. The response sits in an output
// register; a new request can be accepted while it waits, but that request holds in
// its final step until the register is free.
module bitmap_range_id_allocator
  import bria_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  input  logic [ID_W-1:0] port_in_i,
  input  logic [ID_W-1:0] range_start_i,
  input  logic [ID_W-1:0] range_end_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [ID_W-1:0] port_out_o
);

  localparam logic [ID_W:0]  MaxIdExt = (ID_W + 1)'(NUM_IDS - 1);
  localparam logic [ID_W:0]  NumIdsExt = (ID_W + 1)'(NUM_IDS);
  localparam logic [WAW-1:0] LastRow = WAW'(MAP_WORDS - 1);

  state_e state_q, state_d;

  // Request registers
  op_e             op_q;
  logic [ID_W-1:0] id_q, lo_q, hi_q;

  // Scan control
  logic [WAW-1:0]    row_q, lo_row_q, last_row_q, clr_row_q;
  logic [WORD_W-1:0] lo_mask_q, hi_mask_q;

  // Pending write and result
  logic [WORD_W-1:0] word_q;
  logic [BIT_W-1:0]  bit_q;
  logic              set_q;
  status_e           res_status_q;
  logic [ID_W-1:0]   res_port_q;

  // Output register
  logic            out_valid_q;
  status_e         status_q;
  logic [ID_W-1:0] port_out_q;

  // RAM port
  logic              ram_we, ram_re;
  logic [WAW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Start-step decode
  logic [ID_W-1:0] last_clamp;
  logic            id_in_map;
  logic            start_done;
  status_e         start_status;
  logic [BIT_W-1:0] hi_shift;

  // Check-step decode
  ffz_t            ffz_res;
  logic            old_bit;
  logic            row_is_last;
  logic            load_out;
  logic            accept;

  assign accept = in_valid_i && in_ready_o;

  // Acquire never looks past the last identifier the map holds.
  assign last_clamp = ({1'b0, hi_q} > MaxIdExt) ? MaxIdExt[ID_W-1:0] : hi_q;
  assign id_in_map  = {1'b0, id_q} < NumIdsExt;
  assign hi_shift   = BIT_W'(WORD_W - 1) - last_clamp[BIT_W-1:0];

  always_comb begin
    start_done   = 1'b1;
    start_status = ST_OK;
    case (op_q)
      OP_ACQUIRE: begin
        if (lo_q >= hi_q) begin
          start_status = ST_BAD_RANGE;
        end else if ({1'b0, lo_q} > {1'b0, last_clamp}) begin
          start_status = ST_NO_FREE;
        end else begin
          start_done = 1'b0;
        end
      end
      OP_RELEASE: begin
        start_done = (id_q == '0) || !id_in_map;
      end
      OP_MARK: begin
        if (id_q == '0) begin
          start_done = 1'b1;
        end else if (!id_in_map) begin
          start_status = ST_USED;
        end else begin
          start_done = 1'b0;
        end
      end
      default: begin
        start_done = 1'b1;
      end
    endcase
  end

  assign row_is_last = (row_q == last_row_q);
  assign old_bit     = ram_rdata[id_q[BIT_W-1:0]];

  bria_ffz u_ffz (
    .word_i    (ram_rdata),
    .lo_mask_i (lo_mask_q),
    .use_lo_i  (row_q == lo_row_q),
    .hi_mask_i (hi_mask_q),
    .use_hi_i  (row_is_last),
    .res_o     (ffz_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_row_q == LastRow) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = start_done ? S_FINISH : S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (op_q == OP_ACQUIRE) begin
          if (ffz_res.found) begin
            state_d = S_WRITE;
          end else if (row_is_last) begin
            state_d = S_FINISH;
          end
        end else if (op_q == OP_MARK && old_bit) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = row_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = row_q;
    load_out   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row_q;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_CHECK: begin
        // Prefetch the next row; used only if the scan moves on.
        ram_re    = 1'b1;
        ram_raddr = WAW'(row_q + 1'b1);
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = set_q ? (word_q | (WORD_W'(1) << bit_q))
                          : (word_q & ~(WORD_W'(1) << bit_q));
      end
      S_FINISH: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  bria_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (WAW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_row_q <= WAW'(clr_row_q + 1'b1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(operation_i);
      id_q <= port_in_i;
      lo_q <= range_start_i;
      hi_q <= range_end_i;
    end

    case (state_q)
      S_START: begin
        row_q        <= (op_q == OP_ACQUIRE) ? WAW'(lo_q >> BIT_W) : WAW'(id_q >> BIT_W);
        lo_row_q     <= WAW'(lo_q >> BIT_W);
        last_row_q   <= WAW'(last_clamp >> BIT_W);
        lo_mask_q    <= (WORD_W'(1) << lo_q[BIT_W-1:0]) - WORD_W'(1);
        hi_mask_q    <= ~({WORD_W{1'b1}} >> hi_shift);
        res_status_q <= start_status;
        res_port_q   <= '0;
        bit_q        <= id_q[BIT_W-1:0];
      end
      S_CHECK: begin
        word_q <= ram_rdata;
        if (op_q == OP_ACQUIRE) begin
          set_q <= 1'b1;
          if (ffz_res.found) begin
            bit_q      <= ffz_res.pos;
            res_port_q <= ID_W'({row_q, ffz_res.pos});
          end else if (row_is_last) begin
            res_status_q <= ST_NO_FREE;
          end else begin
            row_q <= WAW'(row_q + 1'b1);
          end
        end else begin
          set_q <= (op_q == OP_MARK);
          if (op_q == OP_MARK && old_bit) begin
            res_status_q <= ST_USED;
          end
        end
      end
      default: begin
      end
    endcase

    if (load_out) begin
      status_q   <= res_status_q;
      port_out_q <= res_port_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign port_out_o  = port_out_q;

endmodule

### rtl/core/bria_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bria_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bria_ffz.sv
// Find-first-zero unit: lowest clear bit of a map word after range masking.
module bria_ffz
  import bria_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  input  logic [WORD_W-1:0] lo_mask_i,
  input  logic              use_lo_i,
  input  logic [WORD_W-1:0] hi_mask_i,
  input  logic              use_hi_i,
  output ffz_t              res_o
);

  logic [WORD_W-1:0]  scan;
  logic [GRP_N-1:0]   grp_zero;
  logic [GRP_AW-1:0]  sel_grp;
  logic [GRP_W-1:0]   grp_bits;
  logic [GBIT_AW-1:0] sel_bit;

  // Out-of-range bits are forced to "used" so they never win.
  assign scan = word_i | (use_lo_i ? lo_mask_i : '0) | (use_hi_i ? hi_mask_i : '0);

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_zero[g] = ~&scan[g*GRP_W +: GRP_W];
    end
  end

  always_comb begin
    sel_grp = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_zero[g]) begin
        sel_grp = GRP_AW'(g);
      end
    end
  end

  assign grp_bits = scan[{sel_grp, {GBIT_AW{1'b0}}} +: GRP_W];

  always_comb begin
    sel_bit = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        sel_bit = GBIT_AW'(b);
      end
    end
  end

  assign res_o.found = |grp_zero;
  assign res_o.pos   = {sel_grp, sel_bit};

endmodule

### rtl/core/bria_chk.sv
// Port-level assertion checker for the allocator, bound to the top level.
module bria_chk
  import bria_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic [1:0]      operation_i,
  input logic [ID_W-1:0] port_in_i,
  input logic [ID_W-1:0] range_start_i,
  input logic [ID_W-1:0] range_end_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [1:0]      status_o,
  input logic [ID_W-1:0] port_out_o
);

  // A stalled response beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(port_out_o))
    else $error("response beat changed while stalled");

  // One request at a time: ready drops right after a request beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // Failed responses carry no identifier.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NO_FREE || status_o == ST_USED ||
                    status_o == ST_BAD_RANGE) |-> port_out_o == '0)
    else $error("failed response with nonzero identifier");

  // A response is loaded only from the busy part of a request.
  a_resp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response appeared while idle");

endmodule

bind bitmap_range_id_allocator bria_chk u_bria_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .operation_i   (operation_i),
  .port_in_i     (port_in_i),
  .range_start_i (range_start_i),
  .range_end_i   (range_end_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .port_out_o    (port_out_o)
);

### test/alloc_check.sv
`timescale 1ns / 100ps
// Response checker for the identifier allocator: tracks the used map and compares each response beat.
module alloc_check
  import bria_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [1:0]      operation_i,
  input  logic [ID_W-1:0] port_in_i,
  input  logic [ID_W-1:0] range_start_i,
  input  logic [ID_W-1:0] range_end_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [1:0]      status_i,
  input  logic [ID_W-1:0] port_out_i,
  output int              fail_count_o,
  output int              pending_o
);

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] id;
  } grant_t;

  bit     id_taken [NUM_IDS];
  grant_t grants_due [$];

  // Applies one request to the local map and returns the response it must produce.
  function automatic grant_t predict_grant(op_e op, logic [ID_W-1:0] id,
                                           logic [ID_W-1:0] lo, logic [ID_W-1:0] hi);
    grant_t g;
    g.status = ST_OK;
    g.id     = '0;
    case (op)
      OP_ACQUIRE: begin
        if (lo >= hi) begin
          g.status = ST_BAD_RANGE;
        end else begin
          g.status = ST_NO_FREE;
          for (int unsigned i = lo; i <= hi; i++) begin
            if (!id_taken[i]) begin
              id_taken[i] = 1'b1;
              g.status    = ST_OK;
              g.id        = i[ID_W-1:0];
              break;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (id != '0) id_taken[id] = 1'b0;
      end
      OP_MARK: begin
        if (id != '0) begin
          if (id_taken[id]) g.status = ST_USED;
          else id_taken[id] = 1'b1;
        end
      end
      OP_NOP: ;
    endcase
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      id_taken = '{default: 1'b0};
      grants_due.delete();
    end else begin
      // response first: a request taken on this edge cannot be answered on it
      if (out_valid_i && out_ready_i) begin
        if (grants_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: response beat with none pending: status %0d port %0d",
                     $realtime, status_i, port_out_i);
        end else begin
          want = grants_due.pop_front();
          if (status_i !== want.status || port_out_i !== want.id) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: expected status %s port %0d, got status %0d port %0d",
                       $realtime, want.status.name(), want.id, status_i, port_out_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        grants_due.push_back(predict_grant(op_e'(operation_i), port_in_i,
                                           range_start_i, range_end_i));
    end
    pending_o = grants_due.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the identifier allocator: clock, reset, request stimulus and response pacing.
module tb_top;
  import bria_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_BEATS = 1630;
  localparam int CHUNK        = 40;
  localparam int TAIL_CYCLES  = 64;

  // Handshake pacing: idle percentages on the request and response sides
  typedef enum int {PACE_FULL, PACE_SRC_GAPS, PACE_SINK_STALL, PACE_BOTH} pace_e;

  logic            clk         = 1'b0;
  logic            rst_n       = 1'b0;
  logic            in_valid    = 1'b0;
  logic            in_ready;
  logic [1:0]      operation   = '0;
  logic [ID_W-1:0] port_in     = '0;
  logic [ID_W-1:0] range_start = '0;
  logic [ID_W-1:0] range_end   = '0;
  logic            out_valid;
  logic            out_ready   = 1'b0;
  logic [1:0]      status;
  logic [ID_W-1:0] port_out;

  pace_e pace        = PACE_FULL;
  int    holds_asked = 0;
  int    holds_done  = 0;
  int    hold_left   = 0;
  int    fail_count;
  int    pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_range_id_allocator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .operation_i   (operation),
    .port_in_i     (port_in),
    .range_start_i (range_start),
    .range_end_i   (range_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .port_out_o    (port_out)
  );

  alloc_check u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .operation_i   (operation),
    .port_in_i     (port_in),
    .range_start_i (range_start),
    .range_end_i   (range_end),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .port_out_i    (port_out),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom);
  endfunction

  function automatic logic [ID_W-1:0] clamp_id(int v);
    return (v > 65535) ? 16'hFFFF : ID_W'(v);
  endfunction

  // Called and returns at a falling edge. Valid stays up across back-to-back
  // beats; an idle gap drops it for whole cycles only.
  task automatic send_beat(op_e op, logic [ID_W-1:0] id,
                           logic [ID_W-1:0] lo, logic [ID_W-1:0] hi);
    while (chance(pace == PACE_SRC_GAPS ? 61 : pace == PACE_BOTH ? 7 : 0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    port_in     <= id;
    range_start <= lo;
    range_end   <= hi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering requests until every outstanding response has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // One random beat aimed at a small window, so the window fills up, ids
  // collide on mark-used and releases reopen holes for later acquires.
  task automatic send_random(int base, int span);
    int r;
    int lo;
    int hi;
    r  = $urandom_range(0, 99);
    lo = base + $urandom_range(0, span / 2);
    hi = lo + $urandom_range(1, span);
    if (r < 45) begin
      send_beat(OP_ACQUIRE, any_id(), clamp_id(lo), clamp_id(hi));
    end else if (r < 65) begin
      send_beat(OP_RELEASE, clamp_id(base + $urandom_range(0, span)), any_id(), any_id());
    end else if (r < 85) begin
      send_beat(OP_MARK, clamp_id(base + $urandom_range(0, span)), any_id(), any_id());
    end else if (r < 90) begin
      send_beat(OP_NOP, any_id(), any_id(), any_id());
    end else if (r < 97) begin
      // noise: anything the fields allow
      send_beat(op_e'($urandom_range(0, 3)), any_id(), any_id(), any_id());
    end else if (r < 99) begin
      // start at or above end
      lo = $urandom_range(0, 65535);
      send_beat(OP_ACQUIRE, any_id(), ID_W'(lo), ID_W'($urandom_range(0, lo)));
    end else begin
      // wide search up to the top of the id space
      send_beat(OP_ACQUIRE, any_id(), ID_W'($urandom_range(0, 1023)), 16'hFFFF);
    end
  endtask

  // Response side. A requested hold keeps ready low for HOLD_CYCLES so the
  // output register and the pending request back up into in_ready.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !chance(pace == PACE_SINK_STALL ? 61 : pace == PACE_BOTH ? 7 : 0);
    end
  end

  // Watchdog: clear sweep after reset plus all traffic fits well inside this.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int base;
    int span;
    base = 0;
    span = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part; the block is still clearing its map, in_ready holds us off
    send_beat(OP_MARK,    16'd0,      16'd0,      16'd0);      // id zero: mark ignored
    send_beat(OP_RELEASE, 16'd0,      16'd0,      16'd0);      // id zero: release ignored
    send_beat(OP_NOP,     16'hFFFF,   16'hFFFF,   16'hFFFF);   // no-op operation
    send_beat(OP_ACQUIRE, 16'hFFFF,   16'd0,      16'd1);      // id zero can be acquired
    send_beat(OP_ACQUIRE, 16'd0,      16'd0,      16'd1);      // -> 1
    send_beat(OP_ACQUIRE, 16'd0,      16'd0,      16'd1);      // range full
    send_beat(OP_ACQUIRE, 16'd0,      16'd5,      16'd5);      // start equals end
    send_beat(OP_ACQUIRE, 16'd0,      16'hFFFF,   16'd0);      // start above end
    send_beat(OP_ACQUIRE, 16'd0,      16'hFFFE,   16'hFFFF);   // top of id space
    send_beat(OP_MARK,    16'hFFFF,   16'd0,      16'd0);
    send_beat(OP_MARK,    16'hFFFF,   16'hFFFF,   16'hFFFF);   // already used
    send_beat(OP_ACQUIRE, 16'd0,      16'hFFFE,   16'hFFFF);   // full at the top
    send_beat(OP_RELEASE, 16'hFFFF,   16'd0,      16'd0);
    send_beat(OP_ACQUIRE, 16'd0,      16'hFFFE,   16'hFFFF);   // reopened -> 65535
    send_beat(OP_RELEASE, 16'd1,      16'd0,      16'd0);
    send_beat(OP_ACQUIRE, 16'd0,      16'd0,      16'd3);      // hole at 1
    send_beat(OP_MARK,    16'd2,      16'd0,      16'd0);
    send_beat(OP_ACQUIRE, 16'd0,      16'd0,      16'd3);      // -> 3
    send_beat(OP_ACQUIRE, 16'd0,      16'd0,      16'hFFFF);   // whole id space -> 4
    send_beat(OP_RELEASE, 16'h8000,   16'd0,      16'd0);      // release of a free id
    send_beat(OP_ACQUIRE, 16'hFFFF,   16'd100,    16'hFFFF);   // port_in ignored
    send_beat(OP_MARK,    16'd100,    16'd0,      16'd0);      // taken by the acquire
    wait_drained();

    // Random part in chunks; each chunk gets a fresh window and pacing
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k % CHUNK == 0) begin
        pace = pace_e'((k / CHUNK) % 4);
        base = $urandom_range(0, 65535);
        span = $urandom_range(1, 48);
        if ((k / CHUNK) % 10 == 3) holds_asked++;
        if ((k / CHUNK) % 10 == 7) wait_drained();
      end
      send_random(base, span);
    end

    pace = PACE_FULL;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bria_pkg.sv
rtl/core/bria_ram.sv
rtl/core/bria_ffz.sv
rtl/core/bitmap_range_id_allocator.sv
rtl/core/bria_chk.sv
test/alloc_check.sv
test/tb_top.sv
